@@ rtl/ssd_pkg.sv @@
// Package for the seven-segment scan display core: command and status types,
// mode codes and the segment lookup table. It depends on nothing else.
package ssd_pkg;

    localparam int unsigned CODE_W       = 5;
    localparam int unsigned SYMBOL_COUNT = 24;
    localparam logic [CODE_W-1:0] BLANK_CODE = 5'd10;
    localparam logic [7:0] POINT_CLEAR_MASK = 8'h7F;

    // Multiply by this and shift right by RECIP_SHIFT to divide a 32-bit value by ten.
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;

    localparam logic [2:0] MODE_TICK        = 3'd0;
    localparam logic [2:0] MODE_SET_CODE    = 3'd1;
    localparam logic [2:0] MODE_SET_DIGIT   = 3'd2;
    localparam logic [2:0] MODE_DIGIT_POINT = 3'd3;
    localparam logic [2:0] MODE_NUMBER      = 3'd4;
    localparam logic [2:0] MODE_CODE_KEEP   = 3'd5;
    localparam logic [2:0] MODE_CLEAR       = 3'd6;

    typedef struct packed {
        logic accept;
        logic mul_step;
        logic dig_step;
        logic blank_step;
    } ssd_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic is_number;
        logic len_zero;
        logic last_digit;
    } ssd_status_t;

    function automatic logic [7:0] seg_lookup(input logic [CODE_W-1:0] code);
        logic [7:0] seg;
        case (code)
            5'd0:    seg = 8'hC0;
            5'd1:    seg = 8'hF9;
            5'd2:    seg = 8'hA4;
            5'd3:    seg = 8'hB0;
            5'd4:    seg = 8'h99;
            5'd5:    seg = 8'h92;
            5'd6:    seg = 8'h82;
            5'd7:    seg = 8'hF8;
            5'd8:    seg = 8'h80;
            5'd9:    seg = 8'h90;
            5'd10:   seg = 8'hFF;
            5'd11:   seg = 8'hBF;
            5'd12:   seg = 8'hC1;
            5'd13:   seg = 8'h89;
            5'd14:   seg = 8'hC8;
            5'd15:   seg = 8'h8C;
            5'd16:   seg = 8'hC6;
            5'd17:   seg = 8'h88;
            5'd18:   seg = 8'hC0;
            5'd19:   seg = 8'hAF;
            5'd20:   seg = 8'h7F;
            5'd21:   seg = 8'h8E;
            5'd22:   seg = 8'h86;
            5'd23:   seg = 8'hC7;
            default: seg = 8'hFF;
        endcase
        return seg;
    endfunction

endpackage

@@ rtl/ssd_if.sv @@
// Valid/ready channel interfaces for the display core: one for command beats
// and one for segment beats. They depend on nothing else.
interface ssd_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [7:0]  position;
    logic [31:0] number;
    logic [7:0]  symbol;
    logic [7:0]  length;
    logic        zero_blank;

    modport source (output valid, mode, position, number, symbol, length, zero_blank,
                    input ready);
    modport sink   (input valid, mode, position, number, symbol, length, zero_blank,
                    output ready);
endinterface

interface ssd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit_enable;
    logic [7:0] segments;

    modport source (output valid, digit_enable, segments, input ready);
    modport sink   (input valid, digit_enable, segments, output ready);
endinterface

@@ rtl/seven_segment_scan_display_core.sv @@
// Top level of the seven-segment scan display core: joins the controller and
// the datapath to the channels. Depends on ssd_pkg, ssd_if, ssd_ctrl and ssd_dp.
//
// The item channel carries command beats: a tick, a symbol or digit write to
// one position, a number to spread over several positions, or a clear. The
// result channel carries one beat per tick: a one-hot digit enable and the
// active-low segment byte of the digit under the scan index, with bit 7 low
// when that digit's point is set. Other commands give no result beat.
// A tick, a single write and a clear take effect as they are accepted, and the tick's
// result is valid in the next cycle from an output register. In number mode,
// each of the L digits (L is the length clipped to DIGITS) passes a shared 32x32
// reciprocal multiplier and a registered remainder step, and a final step blanks
// leading zeros when zero_blank is set. Further beats wait until it ends.
// The output register lets a new beat in whenever it is empty or being read;
// while the receiver stalls a result, no new beat is taken.
// Reset sets every digit to blank with its point off and the scan index to
// the first digit; the output register comes up empty.
module seven_segment_scan_display_core #(
    parameter int unsigned DIGITS = 8
) (
    input logic clk,
    input logic rst_n,
    ssd_in_if.sink    item,
    ssd_out_if.source result
);
    import ssd_pkg::*;

    ssd_cmd_t    cmd;
    ssd_status_t status;

    ssd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ssd_dp #(
        .DIGITS (DIGITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .mode          (item.mode),
        .position      (item.position),
        .number        (item.number),
        .symbol        (item.symbol),
        .length        (item.length),
        .zero_blank    (item.zero_blank),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .digit_enable  (result.digit_enable),
        .segments      (result.segments)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.mul_step, cmd.dig_step, cmd.blank_step}))
        else $error("More than one datapath command in a cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_step |=> cmd.dig_step)
        else $error("Multiply step not followed by a digit step.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dig_step |=> (cmd.mul_step || cmd.blank_step))
        else $error("Digit step not followed by a multiply or blanking step.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> $onehot0(result.digit_enable))
        else $error("Digit enable is not one-hot.");

endmodule

@@ rtl/ssd_ctrl.sv @@
// Controller of the display core: accepts command beats and sequences the
// digit conversion of number mode. Depends on ssd_pkg.
module ssd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    input  ssd_pkg::ssd_status_t status,
    output ssd_pkg::ssd_cmd_t   cmd
);
    import ssd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL   = 4'b0010,
        ST_DIG   = 4'b0100,
        ST_BLANK = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = !status.out_busy || out_ready;
                cmd.accept = in_valid && in_ready;
                if (cmd.accept && status.is_number && !status.len_zero)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ST_DIG;
            end
            ST_DIG:
            begin
                cmd.dig_step = 1'b1;
                state_next   = status.last_digit ? ST_BLANK : ST_MUL;
            end
            ST_BLANK:
            begin
                cmd.blank_step = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/ssd_dp.sv @@
// Datapath of the display core: symbol and point buffers, scan index, the
// divide-by-ten unit of number mode and the output register. Depends on ssd_pkg.
module ssd_dp #(
    parameter int unsigned DIGITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssd_pkg::ssd_cmd_t    cmd,
    output ssd_pkg::ssd_status_t status,
    input  logic [2:0]           mode,
    input  logic [7:0]           position,
    input  logic [31:0]          number,
    input  logic [7:0]           symbol,
    input  logic [7:0]           length,
    input  logic                 zero_blank,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           digit_enable,
    output logic [7:0]           segments
);
    import ssd_pkg::*;

    localparam int unsigned IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int unsigned CNT_W = $clog2(DIGITS + 1);
    localparam logic [7:0] DIGITS_B = 8'(DIGITS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGITS - 1);

    logic [CODE_W-1:0] sym_reg [DIGITS];
    logic [DIGITS-1:0] pt_reg;
    logic [IDX_W-1:0]  scan_reg;

    logic [31:0]       value_reg;
    logic [63:0]       prod_reg;
    logic [7:0]        pos_reg;
    logic [7:0]        start_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic              lead_reg;

    logic              out_valid_reg;
    logic [7:0]        out_en_reg;
    logic [7:0]        out_seg_reg;

    logic [CNT_W-1:0]  len_clip;
    logic [CODE_W-1:0] sym_code;
    logic [CODE_W-1:0] dig_code;
    logic [28:0]       quot;
    logic [31:0]       rem;
    logic [3:0]        digit;
    logic [CNT_W-1:0]  hi_eff;
    logic [CNT_W-1:0]  blank_cnt;
    logic [DIGITS-1:0] blank_hit;

    logic              tick;
    logic              clr;
    logic              wr_en;
    logic              wr_ok;
    logic [7:0]        wr_pos;
    logic [IDX_W-1:0]  wr_idx;
    logic [CODE_W-1:0] wr_code;
    logic              pt_en;
    logic              pt_val;

    logic [7:0]        en_next;
    logic [7:0]        seg_next;

    assign len_clip = (length > DIGITS_B) ? CNT_W'(DIGITS) : length[CNT_W-1:0];
    assign sym_code = (symbol < 8'(SYMBOL_COUNT)) ? symbol[CODE_W-1:0] : BLANK_CODE;
    assign dig_code = (number > 32'd9) ? BLANK_CODE : number[CODE_W-1:0];

    assign quot  = prod_reg[63:RECIP_SHIFT];
    assign rem   = value_reg - {quot, 3'b000} - {2'b00, quot, 1'b0};
    assign digit = rem[3:0];

    assign hi_eff    = (hi_reg == '0) ? CNT_W'(1) : hi_reg;
    assign blank_cnt = len_reg - hi_eff;

    always_comb
    begin
        for (int p = 0; p < DIGITS; p++)
        begin
            blank_hit[p] = (8'(p) - start_reg) < 8'(blank_cnt);
        end
    end

    always_comb
    begin
        tick    = 1'b0;
        clr     = 1'b0;
        wr_en   = 1'b0;
        wr_pos  = position;
        wr_code = BLANK_CODE;
        pt_en   = 1'b0;
        pt_val  = 1'b0;
        if (cmd.accept)
        begin
            unique case (mode)
                MODE_TICK:
                begin
                    tick = 1'b1;
                end
                MODE_SET_CODE:
                begin
                    wr_en   = 1'b1;
                    wr_code = sym_code;
                    pt_en   = 1'b1;
                end
                MODE_SET_DIGIT:
                begin
                    wr_en   = 1'b1;
                    wr_code = dig_code;
                    pt_en   = 1'b1;
                end
                MODE_DIGIT_POINT:
                begin
                    wr_en   = 1'b1;
                    wr_code = dig_code;
                    pt_en   = 1'b1;
                    pt_val  = 1'b1;
                end
                MODE_CODE_KEEP:
                begin
                    wr_en   = 1'b1;
                    wr_code = sym_code;
                end
                MODE_CLEAR:
                begin
                    clr = 1'b1;
                end
                default:
                begin
                    tick = 1'b0;
                end
            endcase
        end
        else if (cmd.dig_step)
        begin
            wr_en   = 1'b1;
            wr_pos  = pos_reg;
            wr_code = {1'b0, digit};
            pt_en   = 1'b1;
        end
        wr_ok  = wr_en && (wr_pos < DIGITS_B);
        wr_idx = wr_pos[IDX_W-1:0];
    end

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            en_next[b] = (32'(scan_reg) == 32'(b));
        end
        seg_next = seg_lookup(sym_reg[scan_reg]);
        if (pt_reg[scan_reg])
        begin
            seg_next = seg_next & POINT_CLEAR_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < DIGITS; p++)
            begin
                sym_reg[p] <= BLANK_CODE;
            end
            pt_reg        <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                for (int p = 0; p < DIGITS; p++)
                begin
                    sym_reg[p] <= BLANK_CODE;
                end
                pt_reg <= '0;
            end
            if (wr_ok)
            begin
                sym_reg[wr_idx] <= wr_code;
                if (pt_en)
                begin
                    pt_reg[wr_idx] <= pt_val;
                end
            end
            if (cmd.blank_step && lead_reg)
            begin
                for (int p = 0; p < DIGITS; p++)
                begin
                    if (blank_hit[p])
                    begin
                        sym_reg[p] <= BLANK_CODE;
                    end
                end
            end
            if (tick)
            begin
                scan_reg      <= (scan_reg == LAST_IDX) ? '0 : scan_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            out_en_reg  <= en_next;
            out_seg_reg <= seg_next;
        end
        if (cmd.accept)
        begin
            value_reg <= number;
            start_reg <= position;
            pos_reg   <= position + 8'(len_clip) - 8'd1;
            len_reg   <= len_clip;
            cnt_reg   <= len_clip;
            k_reg     <= '0;
            hi_reg    <= '0;
            lead_reg  <= zero_blank;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= value_reg * RECIP_TEN;
        end
        if (cmd.dig_step)
        begin
            value_reg <= {3'b000, quot};
            pos_reg   <= pos_reg - 8'd1;
            cnt_reg   <= cnt_reg - 1'b1;
            k_reg     <= k_reg + 1'b1;
            if (digit != 4'd0)
            begin
                hi_reg <= k_reg + 1'b1;
            end
        end
    end

    assign status.out_busy   = out_valid_reg;
    assign status.is_number  = (mode == MODE_NUMBER);
    assign status.len_zero   = (length == 8'd0);
    assign status.last_digit = (cnt_reg == CNT_W'(1));

    assign out_valid    = out_valid_reg;
    assign digit_enable = out_en_reg;
    assign segments     = out_seg_reg;

endmodule

@@ dv/testbench.sv @@
// Testbench for seven_segment_scan_display_core: random and directed command beats
// checked against a behavioral copy of the digit buffer and scan index.
// Depends on ssd_pkg, ssd_if and the core RTL.
module testbench;
    import ssd_pkg::*;

    localparam int unsigned DIGITS = 8;
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES = 400;

    localparam logic [7:0] SEG_PATTERN [SYMBOL_COUNT] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
        8'h80, 8'h90, 8'hFF, 8'hBF, 8'hC1, 8'h89, 8'hC8, 8'h8C,
        8'hC6, 8'h88, 8'hC0, 8'hAF, 8'h7F, 8'h8E, 8'h86, 8'hC7
    };

    typedef struct {
        logic [2:0]  mode;
        logic [7:0]  position;
        logic [31:0] number;
        logic [7:0]  symbol;
        logic [7:0]  length;
        logic        zero_blank;
        int unsigned gap;
    } display_cmd_t;

    typedef struct {
        logic [7:0] digit_enable;
        logic [7:0] segments;
    } segment_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    ssd_in_if  cmd_ch ();
    ssd_out_if seg_ch ();

    seven_segment_scan_display_core #(
        .DIGITS(DIGITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (cmd_ch),
        .result(seg_ch)
    );

    always #6 clk = ~clk;

    display_cmd_t  pending_cmds [$];
    display_cmd_t  current_cmd;
    segment_beat_t expected_beats [$];

    logic [CODE_W-1:0] shown_code [DIGITS];
    logic              shown_point [DIGITS];
    logic [2:0]        scan_pos;

    int unsigned cmds_accepted = 0;
    int unsigned beats_seen = 0;
    int unsigned failures = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    logic        gap_armed = 1'b0;
    logic        rx_hold;

    task automatic clear_display();
        for (int i = 0; i < DIGITS; i++)
        begin
            shown_code[i]  = BLANK_CODE;
            shown_point[i] = 1'b0;
        end
    endtask

    task automatic write_digit(input logic [7:0] slot, input logic [CODE_W-1:0] code,
                               input logic point, input logic keep_point);
        if (slot < DIGITS)
        begin
            shown_code[slot] = code;
            if (!keep_point)
                shown_point[slot] = point;
        end
    endtask

    task automatic apply_display_cmd(input display_cmd_t c);
        logic [CODE_W-1:0] sym_code;
        logic [CODE_W-1:0] dig_code;
        logic [CODE_W-1:0] digs [DIGITS];
        logic [31:0]       rest;
        logic [7:0]        pattern;
        int unsigned       count;
        sym_code = (c.symbol < SYMBOL_COUNT) ? c.symbol[CODE_W-1:0] : BLANK_CODE;
        dig_code = (c.number > 9) ? BLANK_CODE : c.number[CODE_W-1:0];
        case (c.mode)
            MODE_TICK:
            begin
                pattern = SEG_PATTERN[shown_code[scan_pos]];
                if (shown_point[scan_pos])
                    pattern = pattern & POINT_CLEAR_MASK;
                expected_beats.push_back('{8'b1 << scan_pos, pattern});
                scan_pos = (scan_pos == DIGITS - 1) ? 3'd0 : scan_pos + 3'd1;
            end
            MODE_SET_CODE:    write_digit(c.position, sym_code, 1'b0, 1'b0);
            MODE_SET_DIGIT:   write_digit(c.position, dig_code, 1'b0, 1'b0);
            MODE_DIGIT_POINT: write_digit(c.position, dig_code, 1'b1, 1'b0);
            MODE_CODE_KEEP:   write_digit(c.position, sym_code, 1'b0, 1'b1);
            MODE_NUMBER:
            begin
                count = (c.length > DIGITS) ? DIGITS : c.length;
                rest = c.number;
                for (int i = 0; i < count; i++)
                begin
                    digs[count - 1 - i] = CODE_W'(rest % 10);
                    rest = rest / 10;
                end
                if (c.zero_blank)
                begin
                    for (int i = 0; i + 1 < count; i++)
                    begin
                        if (digs[i] != 0)
                            break;
                        digs[i] = BLANK_CODE;
                    end
                end
                for (int i = 0; i < count; i++)
                    write_digit(c.position + 8'(i), digs[i], 1'b0, 1'b0);
            end
            MODE_CLEAR:       clear_display();
            default:          ;
        endcase
    endtask

    task automatic queue_cmd(input logic [2:0] mode, input logic [7:0] position,
                             input logic [31:0] number, input logic [7:0] symbol,
                             input logic [7:0] length, input logic zero_blank,
                             input int unsigned gap);
        pending_cmds.push_back('{mode, position, number, symbol, length, zero_blank, gap});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            gap_left = 0;
            gap_armed = 1'b0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (cmd_ch.valid)
            begin
                apply_display_cmd(current_cmd);
                cmds_accepted++;
            end
            if (pending_cmds.size() > 0 && !gap_armed)
            begin
                gap_left = pending_cmds[0].gap;
                gap_armed = 1'b1;
            end
            if (pending_cmds.size() == 0 || gap_left > 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else
            begin
                current_cmd = pending_cmds.pop_front();
                gap_armed = 1'b0;
                cmd_ch.valid         <= 1'b1;
                cmd_ch.mode          <= current_cmd.mode;
                cmd_ch.position      <= current_cmd.position;
                cmd_ch.number        <= current_cmd.number;
                cmd_ch.symbol        <= current_cmd.symbol;
                cmd_ch.length        <= current_cmd.length;
                cmd_ch.zero_blank    <= current_cmd.zero_blank;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        segment_beat_t want;
        int unsigned   stall_cap;
        if (!rst_n)
        begin
            seg_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (seg_ch.valid && seg_ch.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("segment beat with nothing expected: digit_enable %h segments %h",
                           seg_ch.digit_enable, seg_ch.segments);
                    failures++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (seg_ch.digit_enable !== want.digit_enable)
                    begin
                        $error("digit_enable: expected %h, got %h",
                               want.digit_enable, seg_ch.digit_enable);
                        failures++;
                    end
                    if (seg_ch.segments !== want.segments)
                    begin
                        $error("segments: expected %h, got %h", want.segments, seg_ch.segments);
                        failures++;
                    end
                end
                beats_seen++;
                case ((beats_seen / 120) % 3)
                    0:       stall_cap = 6;
                    1:       stall_cap = 0;
                    default: stall_cap = 2;
                endcase
                stall_left = $urandom_range(0, stall_cap);
            end
            else if (stall_left > 0)
                stall_left--;
            seg_ch.ready <= (stall_left == 0) && !rx_hold;
        end
    end

    // The receiver stops for a long stretch while commands keep coming, so the
    // output register fills and the core has to stall its input.
    initial
    begin
        rx_hold = 1'b0;
        wait (cmds_accepted >= 300);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #(12 * 250000);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        display_cmd_t c;
        int unsigned  pick;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.mode = MODE_TICK;
        cmd_ch.position = '0;
        cmd_ch.number = '0;
        cmd_ch.symbol = '0;
        cmd_ch.length = '0;
        cmd_ch.zero_blank = 1'b0;
        seg_ch.ready = 1'b0;
        clear_display();
        scan_pos = '0;

        queue_cmd(MODE_TICK, 8'd0, 32'd0, 8'd0, 8'd0, 1'b0, 0);
        queue_cmd(MODE_SET_CODE, 8'd0, 32'd0, 8'd0, 8'd0, 1'b0, 0);
        queue_cmd(MODE_SET_CODE, 8'd7, 32'd0, 8'd23, 8'd0, 1'b0, 0);
        queue_cmd(MODE_SET_CODE, 8'd3, 32'd0, 8'd255, 8'd0, 1'b0, 0);
        queue_cmd(MODE_SET_CODE, 8'd8, 32'd0, 8'd1, 8'd0, 1'b0, 0);
        queue_cmd(MODE_SET_DIGIT, 8'd1, 32'd9, 8'd0, 8'd0, 1'b0, 0);
        queue_cmd(MODE_SET_DIGIT, 8'd2, 32'hFFFF_FFFF, 8'd0, 8'd0, 1'b0, 0);
        queue_cmd(MODE_DIGIT_POINT, 8'd4, 32'd0, 8'd0, 8'd0, 1'b0, 0);
        queue_cmd(MODE_DIGIT_POINT, 8'd6, 32'd10, 8'd0, 8'd0, 1'b0, 0);
        queue_cmd(MODE_CODE_KEEP, 8'd4, 32'd0, 8'd20, 8'd0, 1'b0, 0);
        queue_cmd(MODE_CODE_KEEP, 8'd255, 32'd0, 8'd5, 8'd0, 1'b0, 0);
        repeat (8) queue_cmd(MODE_TICK, 8'd0, 32'd0, 8'd0, 8'd0, 1'b0, 0);
        queue_cmd(MODE_NUMBER, 8'd0, 32'hFFFF_FFFF, 8'd0, 8'd255, 1'b0, 0);
        queue_cmd(MODE_NUMBER, 8'd250, 32'd42, 8'd0, 8'd8, 1'b1, 0);
        queue_cmd(MODE_NUMBER, 8'd5, 32'd0, 8'd0, 8'd3, 1'b1, 0);
        queue_cmd(MODE_NUMBER, 8'd2, 32'd7, 8'd0, 8'd0, 1'b1, 0);
        queue_cmd(MODE_UNUSED, 8'd0, 32'd0, 8'd0, 8'd0, 1'b0, 0);
        repeat (8) queue_cmd(MODE_TICK, 8'd0, 32'd0, 8'd0, 8'd0, 1'b0, 0);
        queue_cmd(MODE_CLEAR, 8'd0, 32'd0, 8'd0, 8'd0, 1'b0, 0);

        for (int n = 0; n < 1250; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      c.mode = MODE_TICK;
            else if (pick < 45) c.mode = MODE_SET_CODE;
            else if (pick < 55) c.mode = MODE_SET_DIGIT;
            else if (pick < 63) c.mode = MODE_DIGIT_POINT;
            else if (pick < 81) c.mode = MODE_NUMBER;
            else if (pick < 91) c.mode = MODE_CODE_KEEP;
            else if (pick < 96) c.mode = MODE_CLEAR;
            else                c.mode = MODE_UNUSED;
            c.position = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 9))
                                                     : 8'($urandom_range(0, 255));
            case ($urandom_range(0, 3))
                0:       c.number = $urandom_range(0, 11);
                1:       c.number = $urandom_range(0, 9999);
                2:       c.number = $urandom_range(0, 99999999);
                default: c.number = $urandom;
            endcase
            c.symbol = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 25))
                                                   : 8'($urandom_range(0, 255));
            c.length = ($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, 9))
                                                   : 8'($urandom_range(0, 255));
            c.zero_blank = 1'($urandom_range(0, 1));
            c.gap = ((n / 200) % 2 == 0) ? $urandom_range(0, 6) : 0;
            pending_cmds.push_back(c);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_cmds.size() == 0 && !cmd_ch.valid);
        wait (expected_beats.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
